[rtl/rmf_pkg.sv]
`timescale 1ns / 1ps
// Shared types for the running median filter.
// Used by rmf_cell and running_median_filter; depends on nothing.
package rmf_pkg;

    localparam int SampleWidth = 16;
    localparam int FillWidth   = 4;

    typedef logic [SampleWidth-1:0] t_sample;
    typedef logic [FillWidth-1:0]   t_fill;

    // What one cell hands to the cell above it in the row.
    typedef struct packed {
        t_sample u;
        logic    lt;
        logic    occ;
        t_sample hist;
    } t_link;

endpackage

[rtl/rmf_cell.sv]
`timescale 1ns / 1ps
// One slot of the sorted row plus one tap of the history shift line.
// Depends on rmf_pkg; instantiated in a row by running_median_filter.
module rmf_cell
    import rmf_pkg::*;
#(
    parameter bit IS_FIRST = 1'b0,
    parameter bit IS_LAST  = 1'b0
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_sample i_sample,
    input  t_sample i_oldest,
    input  logic    i_full,
    input  t_link   i_prev,
    input  t_sample i_next_val,
    output t_link   o_link,
    output t_sample o_val
);

    t_sample r_val;
    t_sample r_hist;
    logic    r_occ;
    t_sample n_val;
    t_sample n_hist;
    logic    n_occ;
    t_sample w_u;
    logic    w_live;
    logic    w_lt;

    // Take the oldest sample out, then decide where the new one lands.
    always_comb begin
        w_u    = (i_full && (r_val >= i_oldest) && !IS_LAST) ? i_next_val : r_val;
        w_live = i_full ? !IS_LAST : r_occ;
        w_lt   = w_live && (w_u < i_sample);
        priority if (w_lt) begin
            n_val = w_u;
        end else if (IS_FIRST || i_prev.lt) begin
            n_val = i_sample;
        end else begin
            n_val = i_prev.u;
        end
        n_occ  = IS_FIRST ? 1'b1 : i_prev.occ;
        n_hist = IS_FIRST ? i_sample : i_prev.hist;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else if (i_en) begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val  <= n_val;
            r_hist <= n_hist;
        end
    end

    assign o_link = '{u: w_u, lt: w_lt, occ: r_occ, hist: r_hist};
    assign o_val  = r_val;

endmodule

[rtl/running_median_filter.sv]
`timescale 1ns / 1ps
// Running median filter over a sliding window of 16-bit samples.
// Depends on rmf_pkg and rmf_cell.
//
// Input channel: i_in_valid, o_in_stall, i_sample. A beat moves when valid
// is high and stall is low.
// Output channel: o_out_valid, i_out_stall, o_median, o_fill_count. Each
// input beat yields exactly one output beat.
// A row of WINDOW_LENGTH cells keeps the window sorted; every cell compares
// against its neighbors and removes the oldest sample and inserts the new
// one in the same cycle. The history is a shift line through the same cells.
// An accepted input beat first updates the row; the median is then selected
// from the row into the output register.
// Throughput is one beat per cycle while the output side does not stall.
// When the receiver stalls, one updated result waits in the row and the
// input channel stalls until the output register is free again.
// Reset empties the window and clears both channels; no clearing pass runs.
// fill_count is the held count taken to 4 bits.
module running_median_filter
    import rmf_pkg::*;
#(
    parameter int WINDOW_LENGTH = 15
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_sample i_sample,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_sample o_median,
    output t_fill   o_fill_count
);

    localparam int CntWidth = $clog2(WINDOW_LENGTH + 1);
    localparam int IdxWidth = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;

    logic [CntWidth-1:0] r_held;
    logic                r_pend;
    logic                r_out_valid;
    t_sample             r_median;
    t_fill               r_fill;
    logic                w_full;
    logic                w_out_free;
    logic                w_accept;
    t_link               w_link [WINDOW_LENGTH];
    t_sample             w_val  [WINDOW_LENGTH];

    assign w_full     = (r_held == CntWidth'(WINDOW_LENGTH));
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_pend && !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;

    for (genvar j = 0; j < WINDOW_LENGTH; j++) begin : g_cell
        t_link   w_prev;
        t_sample w_next;
        if (j == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid
            assign w_prev = w_link[j-1];
        end
        if (j == WINDOW_LENGTH - 1) begin : g_top
            assign w_next = '0;
        end else begin : g_low
            assign w_next = w_val[j+1];
        end
        rmf_cell #(
            .IS_FIRST (j == 0),
            .IS_LAST  (j == WINDOW_LENGTH - 1)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (w_accept),
            .i_sample   (i_sample),
            .i_oldest   (w_link[WINDOW_LENGTH-1].hist),
            .i_full     (w_full),
            .i_prev     (w_prev),
            .i_next_val (w_next),
            .o_link     (w_link[j]),
            .o_val      (w_val[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept && !w_full) begin
                r_held <= r_held + 1'b1;
            end
            if (w_accept) begin
                r_pend <= 1'b1;
            end else if (w_out_free) begin
                r_pend <= 1'b0;
            end
            if (w_out_free) begin
                r_out_valid <= r_pend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend && w_out_free) begin
            r_median <= w_val[IdxWidth'(r_held >> 1)];
            r_fill   <= FillWidth'(r_held);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_median     = r_median;
    assign o_fill_count = r_fill;

`ifndef NO_ASSERTIONS
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CntWidth'(WINDOW_LENGTH))
        else $error("held count exceeds window length");

    a_first_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held != '0) |-> w_link[0].occ)
        else $error("lowest cell empty while samples are held");

    a_accept_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_pend)
        else $error("accepted beat left no pending result");
`endif

endmodule
